### src/mmmc_pkg.sv
// ----------------------------------------------------------------------------
// mmmc_pkg
// Types and constants shared by the move machine core and its units.
// ----------------------------------------------------------------------------
package mmmc_pkg;

  typedef struct packed {
    logic        opcode;
    logic [15:0] load_address;
    logic [7:0]  load_data;
  } request_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  out_byte;
    logic [15:0] program_counter;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    ALU_OR,
    ALU_SHL,
    ALU_ADD,
    ALU_NOT,
    ALU_DEC
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [15:0] a;
    logic [7:0]  b;
  } alu_req_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDEC,
    ST_RMEM,
    ST_ROP1,
    ST_ROP2,
    ST_PHI,
    ST_PLO,
    ST_PEND,
    ST_PTRRD,
    ST_POP1,
    ST_POP2,
    ST_POP3,
    ST_RRET,
    ST_WDEC,
    ST_JNZ,
    ST_WPTR,
    ST_PUSH1,
    ST_PUSH2,
    ST_PUSH3,
    ST_PUSH4,
    ST_CALL1,
    ST_CALL2,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_FLO,
    PH_FHI,
    PH_EXEC
  } phase_t;

  typedef enum logic [2:0] {
    OP_RD_PTR,
    OP_RD_POP,
    OP_WR_JNZ,
    OP_WR_PTR,
    OP_WR_PUSH,
    OP_WR_CALL
  } ptr_op_t;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_STEP = 1'b1;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_CHAR    = 3'd1;
  localparam logic [2:0] EV_EXIT    = 3'd2;
  localparam logic [2:0] EV_ODD     = 3'd3;
  localparam logic [2:0] EV_HALTED  = 3'd4;

  localparam logic [7:0]  CONST_PAGE = 8'hff;
  localparam logic [15:0] A_EXIT  = 16'hfeff;
  localparam logic [15:0] A_PUTC  = 16'hfefe;
  localparam logic [15:0] A_OP1   = 16'hfefd;
  localparam logic [15:0] A_OP2   = 16'hfefc;
  localparam logic [15:0] A_OR    = 16'hfefb;
  localparam logic [15:0] A_SHL   = 16'hfefa;
  localparam logic [15:0] A_JNZ   = 16'hfef9;
  localparam logic [15:0] A_JMPH  = 16'hfef7;
  localparam logic [15:0] A_JMPL  = 16'hfef8;
  localparam logic [15:0] A_PTRH  = 16'hfef5;
  localparam logic [15:0] A_PTRA  = 16'hfef4;
  localparam logic [15:0] A_ADD   = 16'hfef3;
  localparam logic [15:0] A_NOT   = 16'hfef2;
  localparam logic [15:0] A_SPH   = 16'hfef0;
  localparam logic [15:0] A_SPL   = 16'hfef1;
  localparam logic [15:0] A_STACK = 16'hfeef;
  localparam logic [15:0] A_CALL  = 16'hfeee;

endpackage

### src/mmmc_mem.sv
// ----------------------------------------------------------------------------
// mmmc_mem
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module mmmc_mem #(
  parameter int DEPTH = 65536
) (
  input  logic              clk,
  input  mmmc_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import mmmc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.addr[AW-1:0]];
  end

endmodule

### src/mmmc_alu.sv
// ----------------------------------------------------------------------------
// mmmc_alu
// Shared arithmetic unit: byte or, shift, add, logical not, 16-bit add and
// decrement for pointers and the program counter.
// ----------------------------------------------------------------------------
module mmmc_alu (
  input  mmmc_pkg::alu_req_t req,
  output logic [15:0]        y
);
  import mmmc_pkg::*;

  logic [7:0] shl;

  always_comb begin
    shl = req.a[7:0] << req.b[2:0];
    unique case (req.op)
      ALU_OR:  y = {8'h00, req.a[7:0] | req.b};
      ALU_SHL: y = (req.b >= 8'd8) ? 16'h0000 : {8'h00, shl};
      ALU_ADD: y = req.a + {8'h00, req.b};
      ALU_NOT: y = {15'd0, (req.a[7:0] == 8'h00)};
      ALU_DEC: y = req.a - 16'd1;
      default: y = 16'h0000;
    endcase
  end

endmodule

### src/memory_mapped_move_machine_core_unit.sv
// ----------------------------------------------------------------------------
// memory_mapped_move_machine_core_unit
// One-instruction move machine: 64 KiB byte memory, mapped read and write
// functions, sequenced over one memory port and one shared arithmetic unit.
// ----------------------------------------------------------------------------
// After reset the memory is cleared one byte a cycle, all MEM_DEPTH bytes, with
// busy high. An item is taken when start is high and busy is low. A load item
// writes its byte at once and its result appears on the next cycle. A step
// item runs through a sequencer that makes every byte access on the single
// memory port, so its length is set by the number of accesses, which grows
// when fetch bytes and the operand go through the stack or pointer functions.
// Each result is shown for exactly one cycle with done high and must be taken
// then: there is no back-pressure.
module memory_mapped_move_machine_core_unit #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mmmc_pkg::request_t request,
  output logic               done,
  output mmmc_pkg::result_t  result
);
  import mmmc_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  state_t      state, state_next;
  phase_t      phase, phase_next;
  ptr_op_t     op, op_next;
  alu_op_t     rop, rop_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic [15:0] pc, pc_next;
  logic [7:0]  acc, acc_next;
  logic        halted, halted_next;
  logic [15:0] mra, mra_next;
  logic [7:0]  lo, lo_next;
  logic [15:0] base, base_next;
  logic [15:0] ptr, ptr_next;
  logic [15:0] tmp, tmp_next;
  logic [7:0]  val, val_next;
  logic [7:0]  op1, op1_next;
  logic [2:0]  fin_kind, fin_kind_next;
  logic [7:0]  fin_byte, fin_byte_next;
  logic        done_next;
  result_t     result_next;

  mem_req_t    mem_req;
  logic [7:0]  rdata;
  alu_req_t    alu_req;
  logic [15:0] alu_y;
  logic        accept;

  mmmc_mem #(
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rdata(rdata)
  );

  mmmc_alu u_alu (
    .req(alu_req),
    .y  (alu_y)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    op_next       = op;
    rop_next      = rop;
    clr_cnt_next  = clr_cnt;
    pc_next       = pc;
    acc_next      = acc;
    halted_next   = halted;
    mra_next      = mra;
    lo_next       = lo;
    base_next     = base;
    ptr_next      = ptr;
    tmp_next      = tmp;
    val_next      = val;
    op1_next      = op1;
    fin_kind_next = fin_kind;
    fin_byte_next = fin_byte;
    done_next     = 1'b0;
    result_next   = result;

    mem_req.we    = 1'b0;
    mem_req.addr  = mra;
    mem_req.wdata = acc;

    alu_req.op    = ALU_ADD;
    alu_req.a     = pc;
    alu_req.b     = 8'd1;

    unique case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = 16'(clr_cnt);
        mem_req.wdata = 8'h00;
        clr_cnt_next  = clr_cnt + 1'b1;
        if (clr_cnt == AW'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (request.opcode == OPC_LOAD) begin
            mem_req.we    = 1'b1;
            mem_req.addr  = request.load_address;
            mem_req.wdata = request.load_data;
            done_next     = 1'b1;
            result_next   = '{event_kind: EV_NONE, out_byte: 8'h00, program_counter: pc};
          end else if (halted) begin
            done_next   = 1'b1;
            result_next = '{event_kind: EV_HALTED, out_byte: 8'h00, program_counter: pc};
          end else if (pc[0]) begin
            halted_next = 1'b1;
            done_next   = 1'b1;
            result_next = '{event_kind: EV_ODD, out_byte: 8'h00, program_counter: pc};
          end else begin
            mra_next      = alu_y;
            phase_next    = PH_FLO;
            fin_kind_next = EV_NONE;
            fin_byte_next = 8'h00;
            state_next    = ST_RDEC;
          end
        end
      end

      // read map decode
      ST_RDEC: begin
        if (mra[15:8] == CONST_PAGE) begin
          val_next   = mra[7:0];
          state_next = ST_RRET;
        end else begin
          unique case (mra) inside
            A_OR, A_SHL, A_ADD, A_NOT: begin
              mem_req.addr = A_OP1;
              unique case (mra)
                A_OR:    rop_next = ALU_OR;
                A_SHL:   rop_next = ALU_SHL;
                A_ADD:   rop_next = ALU_ADD;
                default: rop_next = ALU_NOT;
              endcase
              state_next = ST_ROP1;
            end
            A_PTRA: begin
              base_next  = A_PTRH;
              op_next    = OP_RD_PTR;
              state_next = ST_PHI;
            end
            A_STACK: begin
              base_next  = A_SPH;
              op_next    = OP_RD_POP;
              state_next = ST_PHI;
            end
            default: begin
              mem_req.addr = mra;
              state_next   = ST_RMEM;
            end
          endcase
        end
      end

      ST_RMEM: begin
        val_next   = rdata;
        state_next = ST_RRET;
      end

      ST_ROP1: begin
        op1_next     = rdata;
        mem_req.addr = A_OP2;
        state_next   = ST_ROP2;
      end

      ST_ROP2: begin
        alu_req.op = rop;
        alu_req.a  = {8'h00, op1};
        alu_req.b  = rdata;
        val_next   = alu_y[7:0];
        state_next = ST_RRET;
      end

      // gather a big-endian pointer from base
      ST_PHI: begin
        mem_req.addr = base;
        state_next   = ST_PLO;
      end

      ST_PLO: begin
        ptr_next[15:8] = rdata;
        mem_req.addr   = base + 16'd1;
        state_next     = ST_PEND;
      end

      ST_PEND: begin
        ptr_next[7:0] = rdata;
        unique case (op)
          OP_RD_PTR:  state_next = ST_PTRRD;
          OP_RD_POP:  state_next = ST_POP1;
          OP_WR_JNZ:  state_next = ST_JNZ;
          OP_WR_PTR:  state_next = ST_WPTR;
          OP_WR_PUSH: state_next = ST_PUSH1;
          OP_WR_CALL: state_next = ST_CALL1;
          default:    state_next = ST_IDLE;
        endcase
      end

      ST_PTRRD: begin
        mem_req.addr = ptr;
        state_next   = ST_RMEM;
      end

      ST_POP1: begin
        mem_req.addr = ptr;
        alu_req.a    = ptr;
        alu_req.b    = 8'd1;
        tmp_next     = alu_y;
        state_next   = ST_POP2;
      end

      ST_POP2: begin
        val_next      = rdata;
        mem_req.we    = 1'b1;
        mem_req.addr  = A_SPL;
        mem_req.wdata = tmp[7:0];
        state_next    = ST_POP3;
      end

      ST_POP3: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = A_SPH;
        mem_req.wdata = tmp[15:8];
        state_next    = ST_RRET;
      end

      ST_RRET: begin
        unique case (phase)
          PH_FLO: begin
            lo_next    = val;
            mra_next   = pc;
            phase_next = PH_FHI;
            state_next = ST_RDEC;
          end
          PH_FHI: begin
            mra_next = {val, lo};
            if (pc[1]) begin
              state_next = ST_WDEC;
            end else begin
              phase_next = PH_EXEC;
              state_next = ST_RDEC;
            end
          end
          default: begin
            acc_next   = val;
            state_next = ST_FIN;
          end
        endcase
      end

      // write map decode
      ST_WDEC: begin
        unique case (mra)
          A_EXIT: begin
            halted_next = 1'b1;
            done_next   = 1'b1;
            result_next = '{event_kind: EV_EXIT, out_byte: acc, program_counter: pc};
            state_next  = ST_IDLE;
          end
          A_PUTC: begin
            fin_kind_next = EV_CHAR;
            fin_byte_next = acc;
            state_next    = ST_FIN;
          end
          A_JNZ: begin
            if (acc != 8'h00) begin
              base_next  = A_JMPH;
              op_next    = OP_WR_JNZ;
              state_next = ST_PHI;
            end else begin
              state_next = ST_FIN;
            end
          end
          A_PTRA: begin
            base_next  = A_PTRH;
            op_next    = OP_WR_PTR;
            state_next = ST_PHI;
          end
          A_STACK: begin
            base_next  = A_SPH;
            op_next    = OP_WR_PUSH;
            state_next = ST_PHI;
          end
          A_CALL: begin
            base_next  = A_JMPH;
            op_next    = OP_WR_CALL;
            state_next = ST_PHI;
          end
          default: begin
            mem_req.we   = 1'b1;
            mem_req.addr = mra;
            state_next   = ST_FIN;
          end
        endcase
      end

      ST_JNZ: begin
        pc_next    = ptr;
        state_next = ST_FIN;
      end

      ST_WPTR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = ptr;
        state_next   = ST_FIN;
      end

      ST_PUSH1: begin
        alu_req.op = ALU_DEC;
        alu_req.a  = ptr;
        tmp_next   = alu_y;
        state_next = ST_PUSH2;
      end

      ST_PUSH2: begin
        mem_req.we   = 1'b1;
        mem_req.addr = tmp;
        state_next   = ST_PUSH3;
      end

      ST_PUSH3: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = A_SPL;
        mem_req.wdata = tmp[7:0];
        state_next    = ST_PUSH4;
      end

      ST_PUSH4: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = A_SPH;
        mem_req.wdata = tmp[15:8];
        state_next    = ST_FIN;
      end

      // return address goes where the target was
      ST_CALL1: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = A_JMPL;
        mem_req.wdata = pc[7:0];
        state_next    = ST_CALL2;
      end

      ST_CALL2: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = A_JMPH;
        mem_req.wdata = pc[15:8];
        pc_next       = ptr;
        state_next    = ST_FIN;
      end

      ST_FIN: begin
        alu_req.a   = pc;
        alu_req.b   = 8'd2;
        pc_next     = alu_y;
        done_next   = 1'b1;
        result_next = '{event_kind: fin_kind, out_byte: fin_byte, program_counter: alu_y};
        state_next  = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      pc      <= 16'h0000;
      acc     <= 8'h00;
      halted  <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      pc      <= pc_next;
      acc     <= acc_next;
      halted  <= halted_next;
      done    <= done_next;
    end
    phase    <= phase_next;
    op       <= op_next;
    rop      <= rop_next;
    mra      <= mra_next;
    lo       <= lo_next;
    base     <= base_next;
    ptr      <= ptr_next;
    tmp      <= tmp_next;
    val      <= val_next;
    op1      <= op1_next;
    fin_kind <= fin_kind_next;
    fin_byte <= fin_byte_next;
    result   <= result_next;
  end

endmodule
